@@ design/intersection_phase_controller_assert.svh @@
// Assertion shorthands for the intersection phase controller.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef INTERSECTION_PHASE_CONTROLLER_ASSERT_SVH
`define INTERSECTION_PHASE_CONTROLLER_ASSERT_SVH

// Check that a property holds at every clock edge out of reset.
`define IPC_AST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a clock edge out of reset.
`define IPC_AST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/ipc_pkg.sv @@
package ipc_pkg;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2,
    PH_D = 2'd3
  } phase_t;

  typedef enum logic {
    ACT_TICK   = 1'b0,
    ACT_REPORT = 1'b1
  } action_t;

  localparam logic [2:0] APP_SOUTH = 3'd0;
  localparam logic [2:0] APP_NORTH = 3'd1;
  localparam logic [2:0] APP_WEST  = 3'd2;
  localparam logic [2:0] APP_EAST  = 3'd3;

  localparam logic [1:0] REG_PHASE_A = 2'd0;
  localparam logic [1:0] REG_PHASE_B = 2'd1;
  localparam logic [1:0] REG_PHASE_C = 2'd2;
  localparam logic [1:0] REG_PHASE_D = 2'd3;

  localparam logic [15:0] RST_TICKS_A = 16'd25;
  localparam logic [15:0] RST_TICKS_B = 16'd5;
  localparam logic [15:0] RST_TICKS_C = 16'd25;
  localparam logic [15:0] RST_TICKS_D = 16'd5;

  localparam int OCC_W = 12;

  typedef struct packed {
    action_t    action;
    logic [2:0] approach;
    logic [2:0] lanes;
  } item_t;

  typedef struct packed {
    logic  fire;
    item_t item;
  } step_t;

  typedef struct packed {
    phase_t           phase;
    logic [OCC_W-1:0] occupancy;
    logic [2:0]       served;
  } result_t;

  // Vehicles served under a phase; the either/or pairs count the first bit,
  // otherwise the second, so each pair adds at most one.
  function automatic logic [2:0] served_count(phase_t ph, logic [OCC_W-1:0] occ);
    logic [2:0] cnt;
    cnt = 3'd0;
    unique case (ph)
      PH_A: cnt = 3'(occ[11]) + 3'(occ[6]) + 3'(occ[0]) + 3'(occ[5])
                + 3'(occ[4] | occ[2]) + 3'(occ[1] | occ[3]);
      PH_B: cnt = 3'(occ[11]) + 3'(occ[6]) + 3'(occ[0]) + 3'(occ[2])
                + 3'(occ[3]) + 3'(occ[5]);
      PH_C: cnt = 3'(occ[0]) + 3'(occ[5]) + 3'(occ[11]) + 3'(occ[6])
                + 3'(occ[10] | occ[8]) + 3'(occ[7] | occ[9]);
      PH_D: cnt = 3'(occ[0]) + 3'(occ[5]) + 3'(occ[6]) + 3'(occ[8])
                + 3'(occ[9]) + 3'(occ[11]);
      default: cnt = 3'd0;
    endcase
    return cnt;
  endfunction

endpackage

@@ design/intersection_phase_controller.sv @@
// Four-phase intersection signal controller. Items on the in_ channel are
// either one-second ticks (in_tuser = 0) or lane occupancy reports
// (in_tuser = 1) that replace the 3-bit field of one approach (south, north,
// west, east; other approach codes are dropped). Each tick yields one item on
// the out_ channel carrying the phase in force at the tick, the 12-bit
// occupancy snapshot and the served-vehicle count of that phase; a report
// yields nothing. Phase lengths A..D are written on the cfg_ port (index 0..3,
// a length of 0 acts as 1) and are meant to be written while the block is
// idle. An item passes an input register; the state update and result
// formation sit between it and the output register, so a tick's result
// shows on out_tvalid once it has passed both registers. The block takes
// one item per clock; the output register alone sets the stall behavior:
// a waiting result blocks only ticks, while reports keep flowing past it.
module intersection_phase_controller (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: approach [2:0], lanes [5:3], zero [7:6]
  input  logic [7:0]  in_tdata,
  // in_tuser: action (0 tick, 1 report)
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: phase [1:0], occupancy [13:2], served [16:14], zero [23:17]
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ipc_pkg::item_t   in_item;
  ipc_pkg::item_t   hold_item;
  logic             hold_valid;
  logic             take;
  ipc_pkg::step_t   step;
  ipc_pkg::result_t result;
  logic             out_valid_r;
  ipc_pkg::result_t out_data_r;

  // Unpack the input item.
  assign in_item.action   = ipc_pkg::action_t'(in_tuser);
  assign in_item.approach = in_tdata[2:0];
  assign in_item.lanes    = in_tdata[5:3];

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  ipc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // Advance the held item: reports always, ticks only when the output
  // register is free or is being drained this cycle.
  assign take = hold_valid &&
                (hold_item.action == ipc_pkg::ACT_REPORT || !out_valid_r || out_tready);

  assign step.fire = take;
  assign step.item = hold_item;

  ipc_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .result    (result)
  );

  // Output register: load on an advancing tick, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && hold_item.action == ipc_pkg::ACT_TICK) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hold_item.action == ipc_pkg::ACT_TICK) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r.served, out_data_r.occupancy, out_data_r.phase};

endmodule

@@ design/ipc_in_reg.sv @@
module ipc_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ipc_pkg::item_t in_item,
  input  logic          take,
  output logic          hold_valid,
  output ipc_pkg::item_t hold_item
);

  logic           valid_r;
  ipc_pkg::item_t item_r;

  // Refill whenever the held item leaves in the same cycle.
  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ design/ipc_state.sv @@
module ipc_state (
  input  logic             clk,
  input  logic             rst_n,
  input  ipc_pkg::step_t   step,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [15:0]      cfg_wdata,
  output ipc_pkg::result_t result
);

  logic [15:0]          ticks_r [4];
  ipc_pkg::phase_t      phase_r, phase_nxt;
  logic [15:0]          elapsed_r, elapsed_nxt;
  logic [ipc_pkg::OCC_W-1:0] occ_r, occ_nxt;
  logic [15:0]          len;
  logic [16:0]          elapsed_inc;

  // Phase lengths.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r[0] <= ipc_pkg::RST_TICKS_A;
      ticks_r[1] <= ipc_pkg::RST_TICKS_B;
      ticks_r[2] <= ipc_pkg::RST_TICKS_C;
      ticks_r[3] <= ipc_pkg::RST_TICKS_D;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ipc_pkg::REG_PHASE_A: ticks_r[0] <= cfg_wdata;
        ipc_pkg::REG_PHASE_B: ticks_r[1] <= cfg_wdata;
        ipc_pkg::REG_PHASE_C: ticks_r[2] <= cfg_wdata;
        ipc_pkg::REG_PHASE_D: ticks_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result is taken from the state before this item.
  assign result.phase     = phase_r;
  assign result.occupancy = occ_r;
  assign result.served    = ipc_pkg::served_count(phase_r, occ_r);

  assign len         = (ticks_r[phase_r] == 16'd0) ? 16'd1 : ticks_r[phase_r];
  assign elapsed_inc = {1'b0, elapsed_r} + 17'd1;

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    occ_nxt     = occ_r;
    if (step.fire) begin
      if (step.item.action == ipc_pkg::ACT_REPORT) begin
        unique case (step.item.approach)
          ipc_pkg::APP_SOUTH: occ_nxt[2:0]  = step.item.lanes;
          ipc_pkg::APP_NORTH: occ_nxt[5:3]  = step.item.lanes;
          ipc_pkg::APP_WEST:  occ_nxt[8:6]  = step.item.lanes;
          ipc_pkg::APP_EAST:  occ_nxt[11:9] = step.item.lanes;
          default: ;
        endcase
      end else if (elapsed_inc >= {1'b0, len}) begin
        elapsed_nxt = 16'd0;
        phase_nxt   = ipc_pkg::phase_t'(2'(phase_r + 2'd1));
      end else begin
        elapsed_nxt = elapsed_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ipc_pkg::PH_A;
      elapsed_r <= 16'd0;
      occ_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      occ_r     <= occ_nxt;
    end
  end

endmodule

@@ design/ipc_checker.sv @@
`include "intersection_phase_controller_assert.svh"

module ipc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [23:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  logic       seen_r;
  logic [1:0] last_phase_r;
  logic       out_fire;

  assign out_fire = out_tvalid && out_tready;

  // Track the phase of the last delivered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      last_phase_r <= 2'd0;
    end else if (out_fire) begin
      seen_r       <= 1'b1;
      last_phase_r <= out_tdata[1:0];
    end
  end

  `IPC_AST(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed")
  `IPC_AST_NEVER(a_served_range, out_tvalid && out_tdata[16:14] == 3'd7, "served count out of range")
  `IPC_AST(a_first_phase_a, (out_fire && !seen_r) |-> (out_tdata[1:0] == 2'd0), "first result not in phase A")
  `IPC_AST(a_phase_step, (out_fire && seen_r) |-> (out_tdata[1:0] == last_phase_r || out_tdata[1:0] == 2'(last_phase_r + 2'd1)), "phase skipped")

endmodule

bind intersection_phase_controller ipc_checker u_ipc_checker (.*);

@@ dv/intersection_phase_controller_test.sv @@
module intersection_phase_controller_test;
  import ipc_pkg::*;

  // Track the controller: phase lengths, phase position, occupancy map, and
  // the snapshots that ticks still owe on the out_ channel.
  class phase_scoreboard;
    logic [15:0] phase_len [4];
    phase_t      cur_phase;
    logic [15:0] ticks_in_phase;
    logic [11:0] occ_map;
    result_t     owed_snapshots [$];
    int          failures;

    function new();
      phase_len[0]   = RST_TICKS_A;
      phase_len[1]   = RST_TICKS_B;
      phase_len[2]   = RST_TICKS_C;
      phase_len[3]   = RST_TICKS_D;
      cur_phase      = PH_A;
      ticks_in_phase = '0;
      occ_map        = '0;
      failures       = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Every phase serves lanes 0, 5, 6 and 11; the rest depends on the phase.
    // In A and C two pairs of lanes share one slot each.
    function logic [2:0] vehicles_served(phase_t ph, logic [11:0] occ);
      logic [2:0] n;
      n = 3'(occ[0]) + 3'(occ[5]) + 3'(occ[6]) + 3'(occ[11]);
      case (ph)
        PH_A:    n += 3'(occ[2] | occ[4]) + 3'(occ[1] | occ[3]);
        PH_B:    n += 3'(occ[2]) + 3'(occ[3]);
        PH_C:    n += 3'(occ[8] | occ[10]) + 3'(occ[7] | occ[9]);
        default: n += 3'(occ[8]) + 3'(occ[9]);
      endcase
      return n;
    endfunction

    function void set_length(logic [1:0] idx, logic [15:0] value);
      phase_len[idx] = value;
    endfunction

    function void note_item(action_t act, logic [2:0] app, logic [2:0] lanes);
      result_t     snap;
      logic [16:0] span;
      if (act == ACT_REPORT) begin
        case (app)
          APP_SOUTH: occ_map[2:0]  = lanes;
          APP_NORTH: occ_map[5:3]  = lanes;
          APP_WEST:  occ_map[8:6]  = lanes;
          APP_EAST:  occ_map[11:9] = lanes;
          default: ;
        endcase
        return;
      end
      snap.phase     = cur_phase;
      snap.occupancy = occ_map;
      snap.served    = vehicles_served(cur_phase, occ_map);
      owed_snapshots.push_back(snap);
      // A zero length behaves as one tick; a shortened length that the count
      // already meets ends the phase on this tick.
      span = (phase_len[cur_phase] == 16'd0) ? 17'd1 : 17'(phase_len[cur_phase]);
      if (17'(ticks_in_phase) + 17'd1 >= span) begin
        ticks_in_phase = '0;
        cur_phase      = cur_phase.next();
      end else begin
        ticks_in_phase = ticks_in_phase + 16'd1;
      end
    endfunction

    function void check_result(logic [23:0] word);
      result_t want;
      if (owed_snapshots.size() == 0) begin
        flag($sformatf("unexpected result %h", word));
        return;
      end
      want = owed_snapshots.pop_front();
      if (word[1:0] != want.phase)
        flag($sformatf("phase: expected %0d got %0d", want.phase, word[1:0]));
      if (word[13:2] != want.occupancy)
        flag($sformatf("occupancy: expected %h got %h", want.occupancy, word[13:2]));
      if (word[16:14] != want.served)
        flag($sformatf("served: expected %0d got %0d", want.served, word[16:14]));
    endfunction

    function bit clean();
      if (owed_snapshots.size() != 0)
        flag($sformatf("%0d results never arrived", owed_snapshots.size()));
      return failures == 0;
    endfunction
  endclass

  localparam int QUIET_LIMIT = 5000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES = 300;   // long receiver stall
  localparam int SETTLE      = 4;     // a report may still be in flight

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;
  int quiet_cycles  = 0;

  phase_scoreboard board = new();

  intersection_phase_controller dut (.*);

  always #5 clk = ~clk;

  // Monitor: note inputs before checking outputs so a same-edge pass-through
  // would still line up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.note_item(action_t'(in_tuser), in_tdata[2:0], in_tdata[5:3]);
      if (out_tvalid && out_tready)
        board.check_result(out_tdata);
      if (cfg_valid && cfg_ready)
        board.set_length(cfg_index, cfg_data);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("intersection_phase_controller_test: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // block fills up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
        hold_request = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold valid across back-to-back items; drop it only while idling.
  task automatic send_item(action_t act, logic [2:0] app, logic [2:0] lanes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, lanes, app};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic tick();
    send_item(ACT_TICK, 3'($urandom), 3'($urandom));
  endtask

  task automatic report(logic [2:0] app, logic [2:0] lanes);
    send_item(ACT_REPORT, app, lanes);
  endtask

  // Wait until every owed result is back and any trailing report has passed.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.owed_snapshots.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_lengths(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] d);
    write_length(REG_PHASE_A, a);
    write_length(REG_PHASE_B, b);
    write_length(REG_PHASE_C, c);
    write_length(REG_PHASE_D, d);
    cfg_valid <= 1'b0;
  endtask

  // Mostly valid reports with random lanes, ticks in between, and a few
  // reports from approach codes the block drops.
  task automatic run_random(int count);
    repeat (count) begin
      if ($urandom_range(99) < 40)
        tick();
      else if ($urandom_range(99) < 85)
        report(3'($urandom_range(3)), 3'($urandom_range(7)));
      else
        report(3'($urandom_range(7, 4)), 3'($urandom_range(7)));
    end
  endtask

  task automatic segment(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                         logic [15:0] d);
    settle();
    set_lengths(a, b, c, d);
    run_random(200);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 83;

    // Directed: empty map, full map, cleared map, dropped approaches, and
    // the either/or lane pairs; all within the first phase A.
    tick();
    report(APP_SOUTH, 3'b111);
    report(APP_NORTH, 3'b111);
    report(APP_WEST, 3'b111);
    report(APP_EAST, 3'b111);
    tick();
    report(APP_SOUTH, 3'b000);
    report(APP_NORTH, 3'b000);
    report(APP_WEST, 3'b000);
    report(APP_EAST, 3'b000);
    tick();
    for (int app = 4; app < 8; app++) report(3'(app), 3'b111);
    tick();
    report(APP_SOUTH, 3'b101);
    report(APP_NORTH, 3'b010);
    report(APP_WEST, 3'b101);
    report(APP_EAST, 3'b010);
    tick();
    report(APP_SOUTH, 3'b100);
    report(APP_NORTH, 3'b001);
    tick();

    // Shrink A below the ticks already spent so it ends on the next tick.
    segment(16'd3, 16'd1, 16'd2, 16'd4);
    segment(16'd1, 16'd1, 16'd1, 16'd1);
    segment(16'd0, 16'hFFFF, 16'd0, 16'd2);

    send_idle_pct = 83;
    recv_idle_pct = 38;
    segment(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    segment(16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)),
            16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)));
    segment(16'd2, 16'd3, 16'd1, 16'd1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle();
    set_lengths(16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)));
    hold_request = 1'b1;
    run_random(200);
    segment(RST_TICKS_A, RST_TICKS_B, RST_TICKS_C, RST_TICKS_D);

    settle();
    if (board.clean())
      $display("intersection_phase_controller_test: PASS");
    else
      $display("intersection_phase_controller_test: FAIL");
    $finish;
  end

endmodule
